/* rtl/utt_pkg.sv */
// ----------------------------------------------------------------------------
// utt_pkg: shared types and tables of the UTF-8 to UTF-16 transcoder
// Holds the unit bundle passed from the decoder to the serialiser, the
// cp1252 table for 0x80-0x9f and the byte-to-unit mapping.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int UNIT_W    = 16;
  localparam int MAX_UNITS = 4;
  localparam int CNT_W     = 3;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // lead bytes that restrict the second byte
  localparam logic [7:0] LEAD_E0 = 8'he0;
  localparam logic [7:0] LEAD_F0 = 8'hf0;
  localparam logic [7:0] LEAD_F4 = 8'hf4;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] SUR_HIGH  = 16'hd800;
  localparam logic [15:0] SUR_LOW   = 16'hdc00;

  // units caused by one input byte, slot 0 first
  typedef struct packed {
    logic [MAX_UNITS-1:0][UNIT_W-1:0] unit;
    logic [MAX_UNITS-1:0]             bad;
    logic [CNT_W-1:0]                 cnt;
    logic                             eos;
  } bundle_t;

  // cp1252 mapping of 0x80-0x9f
  function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
    logic [15:0] u;
    case (idx)
      5'd0:  u = 16'h20ac;
      5'd1:  u = 16'h0081;
      5'd2:  u = 16'h201a;
      5'd3:  u = 16'h0192;
      5'd4:  u = 16'h201e;
      5'd5:  u = 16'h2026;
      5'd6:  u = 16'h2020;
      5'd7:  u = 16'h2021;
      5'd8:  u = 16'h02c6;
      5'd9:  u = 16'h2030;
      5'd10: u = 16'h0160;
      5'd11: u = 16'h2039;
      5'd12: u = 16'h0152;
      5'd13: u = 16'h008d;
      5'd14: u = 16'h017d;
      5'd15: u = 16'h008f;
      5'd16: u = 16'h0090;
      5'd17: u = 16'h2018;
      5'd18: u = 16'h2019;
      5'd19: u = 16'h201c;
      5'd20: u = 16'h201d;
      5'd21: u = 16'h2022;
      5'd22: u = 16'h2013;
      5'd23: u = 16'h2014;
      5'd24: u = 16'h02dc;
      5'd25: u = 16'h2122;
      5'd26: u = 16'h0161;
      5'd27: u = 16'h203a;
      5'd28: u = 16'h0153;
      5'd29: u = 16'h009d;
      5'd30: u = 16'h017e;
      5'd31: u = 16'h0178;
      default: u = 16'h0000;
    endcase
    return u;
  endfunction

  // unit for a byte taken on its own: ascii, table, or raw
  function automatic logic [15:0] octet_unit(input logic [7:0] b);
    logic [15:0] u;
    if (b[7:5] == 3'b100) begin
      u = cp1252_map(b[4:0]);
    end else begin
      u = {8'h00, b};
    end
    return u;
  endfunction

  // raw bytes from 0xa0 up carry the bad flag
  function automatic logic octet_bad(input logic [7:0] b);
    return (b >= 8'ha0);
  endfunction

endpackage

/* rtl/utf8_to_utf16_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: UTF-8 byte stream to UTF-16 code units
// Decoder, bundle queue and unit serialiser.
// ----------------------------------------------------------------------------
// Usage
// The in_ channel takes one UTF-8 byte per item, with in_tlast marking the
// last byte of a string. The out_ channel gives one UTF-16 code unit per
// item; out_tuser[0] flags a raw byte from 0xa0 up that is passed through,
// out_tuser[1] marks the last unit caused by one input byte and out_tlast
// the last unit of the string. A byte that only extends a sequence gives
// no item.
// A byte's units are registered in the bundle queue before they are offered.
// Throughput: one byte per cycle while each byte gives at most one unit and
// the receiver is ready; a byte giving more (surrogate pair, broken or
// cut-off sequence, up to four) holds the one-unit-per-cycle serialiser
// until all are sent; a two-entry queue lets the decoder accept meanwhile.
// Reset clears the pending sequence, the queue and the serialiser index.
// When the receiver stalls, the current unit holds and in_tready falls once
// the queue is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_octet
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // code_unit
  output logic [1:0]  out_tuser,  // bad_byte_passed, run_end
  output logic        out_tlast   // string_end
);
  import utt_pkg::*;

  logic    push_valid, push_ready;
  bundle_t push_data;
  logic    head_valid, pop;
  bundle_t head_data;

  utt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_ready    (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  utt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  utt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/utt_front.sv */
// ----------------------------------------------------------------------------
// utt_front: byte decoder
// Accepts one byte per cycle while the queue has room, tracks the pending
// multi-byte sequence and builds the bundle of code units that the byte causes.
// ----------------------------------------------------------------------------
module utt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // in_octet
  input  logic             in_tlast,   // end_of_string
  input  logic             q_ready,
  output logic             push_valid,
  output utt_pkg::bundle_t push_data
);
  import utt_pkg::*;

  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][7:0] cont_r, cont_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [2:0]      seq_r, seq_nxt;

  logic [7:0]  b;
  logic        eos;
  logic        accept;
  logic        pending;
  logic        ok;
  logic        complete;
  logic        is_lead;
  logic        fresh_emit;
  logic [2:0]  fresh_len;
  logic [20:0] scalar;
  logic [20:0] supp_off;
  logic        grow_only;
  logic [7:0]  fl_c0, fl_c1;
  logic [2:0]  fl_cnt, flush_n;
  bundle_t     bnd;

  assign b         = in_tdata;
  assign eos       = in_tlast;
  assign in_tready = q_ready;
  assign accept    = in_tvalid & q_ready;

  // continuation check against the pending lead
  assign pending  = (seq_r != SEQ_NONE);
  always_comb begin
    ok = (b[7:6] == 2'b10);
    if (held_r == 2'd0) begin
      if (lead_r == LEAD_E0 && b < 8'ha0) ok = 1'b0;
      if (lead_r == LEAD_F0 && b < 8'h90) ok = 1'b0;
      if (lead_r == LEAD_F4 && b > 8'h8f) ok = 1'b0;
    end
  end
  assign complete = (({1'b0, held_r} + 3'd2) == seq_r);

  // fresh byte classification
  assign is_lead    = (b inside {[8'hc2:8'hf4]});
  assign fresh_emit = !is_lead || eos;
  assign fresh_len  = (b < 8'he0) ? SEQ_TWO : ((b < 8'hf0) ? SEQ_THREE : SEQ_FOUR);

  // scalar value of a completed sequence
  always_comb begin
    case (seq_r)
      SEQ_TWO:   scalar = {10'd0, lead_r[4:0], b[5:0]};
      SEQ_THREE: scalar = {5'd0, lead_r[3:0], cont_r[0][5:0], b[5:0]};
      default:   scalar = {lead_r[2:0], cont_r[0][5:0], cont_r[1][5:0], b[5:0]};
    endcase
  end
  assign supp_off = scalar - SUPP_BASE;

  // bytes flushed: the new byte joins the held ones when it only extends
  assign grow_only = pending && ok && !complete;
  assign fl_c0   = (grow_only && held_r == 2'd0) ? b : cont_r[0];
  assign fl_c1   = (grow_only && held_r == 2'd1) ? b : cont_r[1];
  assign fl_cnt  = grow_only ? ({1'b0, held_r} + 3'd1) : {1'b0, held_r};
  assign flush_n = 3'd1 + fl_cnt;

  // unit bundle and next sequence state
  always_comb begin
    bnd      = '0;
    bnd.eos  = eos;
    lead_nxt = lead_r;
    cont_nxt = cont_r;
    held_nxt = held_r;
    seq_nxt  = seq_r;

    // flush list, used only by the flushing cases
    bnd.unit[0] = {8'h00, lead_r};
    bnd.bad[0]  = 1'b1;
    bnd.unit[1] = octet_unit(fl_c0);
    bnd.bad[1]  = octet_bad(fl_c0);
    bnd.unit[2] = octet_unit(fl_c1);
    bnd.bad[2]  = octet_bad(fl_c1);

    if (pending && ok && complete) begin
      // finished character, split into a pair above the basic plane
      held_nxt = 2'd0;
      seq_nxt  = SEQ_NONE;
      if (scalar < SUPP_BASE) begin
        bnd.unit[0] = scalar[15:0];
        bnd.bad[0]  = 1'b0;
        bnd.cnt     = 3'd1;
      end else begin
        bnd.unit[0] = SUR_HIGH | {6'd0, supp_off[19:10]};
        bnd.bad[0]  = 1'b0;
        bnd.unit[1] = SUR_LOW | {6'd0, scalar[9:0]};
        bnd.bad[1]  = 1'b0;
        bnd.cnt     = 3'd2;
      end
    end else if (grow_only) begin
      // hold the byte; the end of string flushes what is held
      cont_nxt[held_r[0]] = b;
      held_nxt = held_r + 2'd1;
      bnd.cnt  = 3'd0;
      if (eos) begin
        bnd.cnt  = flush_n;
        held_nxt = 2'd0;
        seq_nxt  = SEQ_NONE;
      end
    end else begin
      // broken sequence flushes first, then the byte is taken fresh
      if (pending) begin
        bnd.cnt = flush_n;
        for (int k = 1; k < MAX_UNITS; k++) begin
          if (CNT_W'(k) == flush_n && fresh_emit) begin
            bnd.unit[k] = octet_unit(b);
            bnd.bad[k]  = octet_bad(b);
          end
        end
        if (fresh_emit) bnd.cnt = flush_n + 3'd1;
      end else if (fresh_emit) begin
        bnd.unit[0] = octet_unit(b);
        bnd.bad[0]  = octet_bad(b);
        bnd.cnt     = 3'd1;
      end else begin
        bnd.cnt = 3'd0;
      end
      held_nxt = 2'd0;
      if (is_lead && !eos) begin
        lead_nxt = b;
        seq_nxt  = fresh_len;
      end else begin
        seq_nxt  = SEQ_NONE;
      end
    end
  end

  assign push_valid = accept && (bnd.cnt != 3'd0);
  assign push_data  = bnd;

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= SEQ_NONE;
      held_r <= 2'd0;
    end else if (accept) begin
      seq_r  <= seq_nxt;
      held_r <= held_nxt;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      lead_r <= lead_nxt;
      cont_r <= cont_nxt;
    end
  end

endmodule

/* rtl/utt_queue.sv */
// ----------------------------------------------------------------------------
// utt_queue: bundle queue
// Short queue of unit bundles between the decoder and the serialiser.
// ----------------------------------------------------------------------------
module utt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  utt_pkg::bundle_t push_data,
  output logic             head_valid,
  input  logic             pop,
  output utt_pkg::bundle_t head_data
);
  import utt_pkg::*;

  bundle_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/utt_back.sv */
// ----------------------------------------------------------------------------
// utt_back: unit serialiser
// Sends the units of the head bundle one per cycle while the receiver is ready and marks the last one.
// ----------------------------------------------------------------------------
module utt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  utt_pkg::bundle_t head_data,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // code_unit
  output logic [1:0]       out_tuser,  // bad_byte_passed, run_end
  output logic             out_tlast   // string_end
);
  import utt_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       fire;

  // current unit of the head bundle
  assign last       = (({1'b0, idx_r} + 3'd1) == head_data.cnt);
  assign out_tvalid = head_valid;
  assign out_tdata  = head_data.unit[idx_r];
  assign out_tuser  = {last, head_data.bad[idx_r]};
  assign out_tlast  = last && head_data.eos;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && last;

  // unit index within the bundle
  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
